>>> rtl/fpba_pkg.sv
// shared types, constants and codes for the fit policy block allocator
package fpba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 16;
	localparam int ALIGN_BYTES  = 4;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int ADDR_W       = 16;
	localparam int LEN_W        = 17;
	localparam int NEED_W       = LEN_W + 1;
	localparam logic [LEN_W-1:0] POOL_MAX   = 17'd65536;
	localparam logic [LEN_W-1:0] POOL_RESET = 17'd4096;
	localparam logic [LEN_W-1:0] POOL_MIN   = LEN_W'(HEADER_BYTES + 4);

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_COUNT = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ZERO     = 3'd1;
	localparam logic [2:0] ST_NOSPACE  = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic REG_POOL   = 1'b0;
	localparam logic REG_POLICY = 1'b1;

	typedef struct packed {
		logic [1:0]        action;
		logic [LEN_W-1:0]  request_size;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] address_out;
		logic [6:0]        fragment_count;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] off;
		logic [LEN_W-1:0]  len;
		logic              used;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CHECK, S_SCAN, S_DECIDE,
		S_SHIFT_UP, S_SPLIT_HI, S_SPLIT_LO, S_SHIFT_DN, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_INIT, CMD_CHECK, CMD_SCAN, CMD_DECIDE,
		CMD_SHIFT_UP, CMD_SPLIT_HI, CMD_SPLIT_LO, CMD_SHIFT_DN
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic immediate;
		logic scan_done;
		logic shift_done;
		logic go_up;
		logic go_dn;
	} sts_t;

endpackage

>>> rtl/fpba_ctrl.sv
// controller state machine sequencing scan, shift and split steps
module fpba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           cfg_init,
	input  fpba_pkg::sts_t sts,
	output fpba_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done
);

	fpba_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpba_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		if (cfg_init) begin
			state_d = fpba_pkg::S_INIT;
		end else begin
			unique case (state_q)
				fpba_pkg::S_INIT:     state_d = fpba_pkg::S_IDLE;
				fpba_pkg::S_IDLE:     if (start) state_d = fpba_pkg::S_CHECK;
				fpba_pkg::S_CHECK: begin
					state_d = sts.immediate ? fpba_pkg::S_DONE : fpba_pkg::S_SCAN;
				end
				fpba_pkg::S_SCAN:     if (sts.scan_done) state_d = fpba_pkg::S_DECIDE;
				fpba_pkg::S_DECIDE: begin
					if (sts.go_up) state_d = fpba_pkg::S_SHIFT_UP;
					else if (sts.go_dn) state_d = fpba_pkg::S_SHIFT_DN;
					else state_d = fpba_pkg::S_DONE;
				end
				fpba_pkg::S_SHIFT_UP: if (sts.shift_done) state_d = fpba_pkg::S_SPLIT_HI;
				fpba_pkg::S_SPLIT_HI: state_d = fpba_pkg::S_SPLIT_LO;
				fpba_pkg::S_SPLIT_LO: state_d = fpba_pkg::S_DONE;
				fpba_pkg::S_SHIFT_DN: if (sts.shift_done) state_d = fpba_pkg::S_DONE;
				fpba_pkg::S_DONE:     state_d = fpba_pkg::S_IDLE;
				default:              state_d = fpba_pkg::S_INIT;
			endcase
		end
	end

	always_comb begin
		cmd.op   = fpba_pkg::CMD_NONE;
		cmd.load = 1'b0;
		busy     = 1'b1;
		done     = 1'b0;
		unique case (state_q)
			fpba_pkg::S_INIT:     cmd.op = fpba_pkg::CMD_INIT;
			fpba_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			fpba_pkg::S_CHECK:    cmd.op = fpba_pkg::CMD_CHECK;
			fpba_pkg::S_SCAN:     cmd.op = fpba_pkg::CMD_SCAN;
			fpba_pkg::S_DECIDE:   cmd.op = fpba_pkg::CMD_DECIDE;
			fpba_pkg::S_SHIFT_UP: cmd.op = fpba_pkg::CMD_SHIFT_UP;
			fpba_pkg::S_SPLIT_HI: cmd.op = fpba_pkg::CMD_SPLIT_HI;
			fpba_pkg::S_SPLIT_LO: cmd.op = fpba_pkg::CMD_SPLIT_LO;
			fpba_pkg::S_SHIFT_DN: cmd.op = fpba_pkg::CMD_SHIFT_DN;
			fpba_pkg::S_DONE:     done = 1'b1;
			default:              cmd.op = fpba_pkg::CMD_NONE;
		endcase
	end

endmodule

>>> rtl/fpba_dp.sv
// datapath: block table memory, scan unit, shift pipeline and result register
module fpba_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fpba_pkg::cmd_t             cmd,
	input  fpba_pkg::req_t             req,
	input  logic [fpba_pkg::LEN_W-1:0] pool,
	input  logic                       policy,
	output fpba_pkg::sts_t             sts,
	output fpba_pkg::rsp_t             rsp
);

	localparam int IW = fpba_pkg::IDX_W;
	localparam int CW = fpba_pkg::CNT_W;
	localparam int NW = fpba_pkg::NEED_W;

	fpba_pkg::entry_t mem [fpba_pkg::MAX_BLOCKS];
	fpba_pkg::entry_t rdata;
	logic             mem_we;
	logic [IW-1:0]    mem_wa, mem_ra;
	fpba_pkg::entry_t mem_wd;

	fpba_pkg::req_t   req_q;
	fpba_pkg::rsp_t   rsp_q;
	logic [CW-1:0]    total_q, rd_q;
	logic             v_s1, more_q, found_q, prv_ok_q, nxt_ok_q;
	logic [IW-1:0]    idx_s1, pick_q;
	logic [fpba_pkg::LEN_W-1:0]  pick_len_q;
	logic [fpba_pkg::ADDR_W-1:0] pick_off_q;
	fpba_pkg::entry_t prev_q, prv_q, nxt_q;
	logic [1:0]       r_q;
	logic [6:0]       cnt_q;

	logic [NW-1:0]    rnd, need;
	logic [NW:0]      need_hdr;
	logic [NW-1:0]    limit;
	logic [fpba_pkg::ADDR_W-1:0] target;
	logic             is_alloc, is_free, is_count;
	logic             fits, better, match, exact, full, pf, nf, re_up, re_dn;
	logic [1:0]       r_d;
	logic [CW-1:0]    d_idx;
	logic [fpba_pkg::LEN_W-1:0] mlen;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata <= mem[mem_ra];
	end

	assign is_alloc = req_q.action == fpba_pkg::ACT_ALLOC;
	assign is_free  = req_q.action == fpba_pkg::ACT_FREE;
	assign is_count = req_q.action == fpba_pkg::ACT_COUNT;

	assign rnd      = ({1'b0, req_q.request_size} + NW'(fpba_pkg::ALIGN_BYTES - 1))
	                  & ~NW'(fpba_pkg::ALIGN_BYTES - 1);
	assign need     = rnd + NW'(fpba_pkg::HEADER_BYTES);
	assign need_hdr = {1'b0, need} + (NW+1)'(fpba_pkg::HEADER_BYTES);
	assign limit    = {1'b0, req_q.request_size} + NW'(fpba_pkg::HEADER_BYTES);
	assign target   = req_q.address - fpba_pkg::ADDR_W'(fpba_pkg::HEADER_BYTES);

	assign fits   = !rdata.used && (({2'b0, rdata.len} > need_hdr) || ({1'b0, rdata.len} == need));
	assign better = policy ? (rdata.len > pick_len_q) : (rdata.len < pick_len_q);
	assign match  = rdata.used && (rdata.off == target);
	assign exact  = {1'b0, pick_len_q} == need;
	assign full   = total_q == CW'(fpba_pkg::MAX_BLOCKS);
	assign pf     = prv_ok_q && !prv_q.used;
	assign nf     = nxt_ok_q && !nxt_q.used;
	assign r_d    = {1'b0, pf} + {1'b0, nf};
	assign d_idx  = pf ? {1'b0, pick_q} : ({1'b0, pick_q} + CW'(1));
	assign mlen   = pick_len_q + (pf ? prv_q.len : '0) + (nf ? nxt_q.len : '0);
	assign re_up  = more_q;
	assign re_dn  = rd_q < total_q;

	always_comb begin
		sts.immediate  = (req_q.action == fpba_pkg::ACT_NONE)
		                 || (is_alloc && req_q.request_size == '0)
		                 || (is_free && req_q.address < fpba_pkg::ADDR_W'(fpba_pkg::HEADER_BYTES));
		sts.scan_done  = !re_dn && !v_s1;
		sts.shift_done = (cmd.op == fpba_pkg::CMD_SHIFT_UP) ? (!re_up && !v_s1) : (!re_dn && !v_s1);
		sts.go_up      = is_alloc && found_q && !exact && !full;
		sts.go_dn      = is_free && found_q && r_d != 2'd0;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_ra = rd_q[IW-1:0];
		unique case (cmd.op)
			fpba_pkg::CMD_INIT: begin
				mem_we = pool > fpba_pkg::POOL_MIN;
				mem_wd = '{off: '0, len: pool, used: 1'b0};
			end
			fpba_pkg::CMD_DECIDE: begin
				if (is_alloc && found_q && exact) begin
					mem_we = 1'b1;
					mem_wa = pick_q;
					mem_wd = '{off: pick_off_q, len: pick_len_q, used: 1'b1};
				end else if (is_free && found_q) begin
					mem_we = 1'b1;
					mem_wa = pf ? (pick_q - IW'(1)) : pick_q;
					mem_wd = '{off: (pf ? prv_q.off : pick_off_q), len: mlen, used: 1'b0};
				end
			end
			fpba_pkg::CMD_SHIFT_UP: begin
				mem_we = v_s1;
				mem_wa = idx_s1 + IW'(1);
				mem_wd = rdata;
			end
			fpba_pkg::CMD_SHIFT_DN: begin
				mem_we = v_s1;
				mem_wa = idx_s1 - IW'(r_q);
				mem_wd = rdata;
			end
			fpba_pkg::CMD_SPLIT_HI: begin
				mem_we = 1'b1;
				mem_wa = pick_q + IW'(1);
				mem_wd = '{off: pick_off_q + need[fpba_pkg::ADDR_W-1:0],
				           len: pick_len_q - need[fpba_pkg::LEN_W-1:0], used: 1'b0};
			end
			fpba_pkg::CMD_SPLIT_LO: begin
				mem_we = 1'b1;
				mem_wa = pick_q;
				mem_wd = '{off: pick_off_q, len: need[fpba_pkg::LEN_W-1:0], used: 1'b1};
			end
			default: mem_we = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			rd_q     <= '0;
			v_s1     <= 1'b0;
			more_q   <= 1'b0;
			found_q  <= 1'b0;
			prv_ok_q <= 1'b0;
			nxt_ok_q <= 1'b0;
		end else begin
			case (cmd.op)
				fpba_pkg::CMD_INIT: begin
					total_q <= (pool > fpba_pkg::POOL_MIN) ? CW'(1) : '0;
					v_s1    <= 1'b0;
				end
				fpba_pkg::CMD_CHECK: begin
					rd_q     <= '0;
					v_s1     <= 1'b0;
					found_q  <= 1'b0;
					prv_ok_q <= 1'b0;
					nxt_ok_q <= 1'b0;
				end
				fpba_pkg::CMD_SCAN: begin
					v_s1 <= re_dn;
					if (re_dn) rd_q <= rd_q + CW'(1);
					if (v_s1) begin
						if (is_alloc && fits) found_q <= 1'b1;
						if (is_free && match && !found_q) begin
							found_q  <= 1'b1;
							prv_ok_q <= idx_s1 != '0;
						end
						if (is_free && found_q && !nxt_ok_q && idx_s1 == pick_q + IW'(1))
							nxt_ok_q <= 1'b1;
					end
				end
				fpba_pkg::CMD_DECIDE: begin
					v_s1 <= 1'b0;
					if (is_alloc) begin
						rd_q   <= total_q - CW'(1);
						more_q <= total_q > ({1'b0, pick_q} + CW'(1));
					end else begin
						rd_q <= d_idx + CW'(r_d);
					end
				end
				fpba_pkg::CMD_SHIFT_UP: begin
					v_s1 <= re_up;
					if (re_up) begin
						rd_q   <= rd_q - CW'(1);
						more_q <= rd_q > ({1'b0, pick_q} + CW'(1));
					end
				end
				fpba_pkg::CMD_SHIFT_DN: begin
					v_s1 <= re_dn;
					if (re_dn) rd_q <= rd_q + CW'(1);
					if (!re_dn && !v_s1) total_q <= total_q - CW'(r_q);
				end
				fpba_pkg::CMD_SPLIT_LO: total_q <= total_q + CW'(1);
				default: v_s1 <= 1'b0;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if ((cmd.op == fpba_pkg::CMD_SCAN && re_dn) || (cmd.op == fpba_pkg::CMD_SHIFT_UP && re_up)
		    || (cmd.op == fpba_pkg::CMD_SHIFT_DN && re_dn))
			idx_s1 <= rd_q[IW-1:0];
		case (cmd.op)
			fpba_pkg::CMD_CHECK: begin
				cnt_q                <= '0;
				rsp_q.address_out    <= '0;
				rsp_q.fragment_count <= '0;
				if (is_alloc && req_q.request_size == '0) rsp_q.status <= fpba_pkg::ST_ZERO;
				else if (is_free) rsp_q.status <= fpba_pkg::ST_NOTFOUND;
				else rsp_q.status <= fpba_pkg::ST_OK;
			end
			fpba_pkg::CMD_SCAN: begin
				if (v_s1) begin
					prev_q <= rdata;
					if (is_count && !rdata.used && limit > {1'b0, rdata.len})
						cnt_q <= cnt_q + 7'd1;
					if ((is_alloc && fits && (!found_q || better)) ||
					    (is_free && match && !found_q)) begin
						pick_q     <= idx_s1;
						pick_len_q <= rdata.len;
						pick_off_q <= rdata.off;
						prv_q      <= prev_q;
					end
					if (is_free && found_q && !nxt_ok_q && idx_s1 == pick_q + IW'(1))
						nxt_q <= rdata;
				end
			end
			fpba_pkg::CMD_DECIDE: begin
				r_q <= r_d;
				if (is_alloc) begin
					if (!found_q) rsp_q.status <= fpba_pkg::ST_NOSPACE;
					else if (!exact && full) rsp_q.status <= fpba_pkg::ST_FULL;
					else begin
						rsp_q.status      <= fpba_pkg::ST_OK;
						rsp_q.address_out <= pick_off_q + fpba_pkg::ADDR_W'(fpba_pkg::HEADER_BYTES);
					end
				end else if (is_free) begin
					rsp_q.status <= found_q ? fpba_pkg::ST_OK : fpba_pkg::ST_NOTFOUND;
				end else begin
					rsp_q.fragment_count <= cnt_q;
				end
			end
			default: rsp_q <= rsp_q;
		endcase
	end

	assign rsp = rsp_q;

endmodule

>>> rtl/fit_policy_block_allocator_unit.sv
// top level: configuration registers, controller and datapath of the block allocator
// throughput: one beat at a time; allocate, free and count each make a
//   one-entry-per-cycle pass over the block table memory
// reset: asynchronous; pool 4096, best fit, table rebuilt in the init state (also after pool write)
// the result strobe lasts one cycle and cannot be held off
module fit_policy_block_allocator_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  fpba_pkg::req_t request,
	output logic           busy,
	output logic           done,
	output fpba_pkg::rsp_t result,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	logic [fpba_pkg::LEN_W-1:0] pool_q;
	logic                       policy_q;
	logic                       wr, cfg_init;
	fpba_pkg::cmd_t             cmd;
	fpba_pkg::sts_t             sts;

	assign pready   = 1'b1;
	assign wr       = psel && penable && pwrite;
	assign cfg_init = wr && (paddr[2] == fpba_pkg::REG_POOL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q   <= fpba_pkg::POOL_RESET;
			policy_q <= 1'b0;
		end else if (wr) begin
			unique case (paddr[2])
				fpba_pkg::REG_POOL: begin
					pool_q <= (pwdata[16:0] > fpba_pkg::POOL_MAX) ? fpba_pkg::POOL_MAX
					                                              : pwdata[16:0];
				end
				fpba_pkg::REG_POLICY: policy_q <= pwdata[0];
				default: policy_q <= policy_q;
			endcase
		end
	end

	assign prdata = (paddr[2] == fpba_pkg::REG_POLICY) ? {31'd0, policy_q} : {15'd0, pool_q};

	fpba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cfg_init (cfg_init),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	fpba_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (request),
		.pool   (pool_q),
		.policy (policy_q),
		.sts    (sts),
		.rsp    (result)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not raise busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");
	a_alloc_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != fpba_pkg::ST_OK |-> result.address_out == '0)
		else $error("address on failed result");
`endif

endmodule
